>>> rtl/mssd_pkg.sv
// Shared types, constants and segment helpers for the multiplexed
// seven-segment display driver. No dependencies.
`default_nettype none

package mssd_pkg;

    // Field widths.
    localparam int VALUE_W  = 16;
    localparam int FRAME_W  = 8;
    localparam int ENABLE_W = 4;
    localparam int MAG_W    = 14;
    localparam int POS_W    = 3;
    localparam int SEG_W    = 7;
    localparam int DIGIT_W  = 4;

    // Default digit count and the most blank frames a load ever shows.
    localparam int NUM_DIGITS_DEF = 4;
    localparam int MAX_BLANKS     = 4;

    // Action codes.
    localparam logic ACT_TICK = 1'b0;
    localparam logic ACT_LOAD = 1'b1;

    // Accepted value range; anything outside is shown as zero.
    localparam logic signed [VALUE_W-1:0] MAX_POSITIVE = 16'sd9999;
    localparam logic signed [VALUE_W-1:0] MIN_NEGATIVE = -16'sd999;

    // Divide by ten: q = (m * 52429) >> 19 is exact for every 14-bit m.
    localparam int                DIV_PROD_W  = 30;
    localparam logic [15:0]       DIV10_RECIP = 16'd52429;
    localparam int                DIV10_SHIFT = 19;
    localparam logic [MAG_W-1:0]  TEN         = 14'd10;

    // Segment and frame codes.
    localparam logic [SEG_W-1:0]    SEG_DASH    = 7'h01;
    localparam logic [FRAME_W-1:0]  FRAME_BLANK = 8'hFF;
    localparam logic [ENABLE_W-1:0] ENABLE_NONE = 4'hF;

    // One accepted input beat.
    typedef struct packed {
        logic                      action;
        logic signed [VALUE_W-1:0] value;
    } t_item;

    // One result beat.
    typedef struct packed {
        logic [FRAME_W-1:0]  shift_frame;
        logic [ENABLE_W-1:0] digit_enable;
        logic                last_of_run;
    } t_result;

    // Segment pattern (A..G in bits 6..0) for a decimal digit.
    function automatic logic [SEG_W-1:0] f_segments(input logic [DIGIT_W-1:0] digit);
        logic [SEG_W-1:0] seg;
        case (digit)
            4'd0:    seg = 7'h7E;
            4'd1:    seg = 7'h30;
            4'd2:    seg = 7'h6D;
            4'd3:    seg = 7'h79;
            4'd4:    seg = 7'h33;
            4'd5:    seg = 7'h5B;
            4'd6:    seg = 7'h5F;
            4'd7:    seg = 7'h70;
            4'd8:    seg = 7'h7F;
            4'd9:    seg = 7'h7B;
            default: seg = 7'h00;
        endcase
        return seg;
    endfunction

    // Shift frame: decimal point off in bit 0, inverted segments above it.
    function automatic logic [FRAME_W-1:0] f_frame(input logic [SEG_W-1:0] seg);
        return {~seg, 1'b1};
    endfunction

    // Active-low digit select; a position past the last digit selects none.
    function automatic logic [ENABLE_W-1:0] f_enable(input logic [POS_W-1:0] pos);
        logic [ENABLE_W-1:0] en;
        case (pos)
            3'd0:    en = 4'b0111;
            3'd1:    en = 4'b1011;
            3'd2:    en = 4'b1101;
            3'd3:    en = 4'b1110;
            default: en = ENABLE_NONE;
        endcase
        return en;
    endfunction

endpackage

`default_nettype wire

>>> rtl/mssd_in_reg.sv
// Input register of the display driver: holds one accepted beat until the
// engine takes it. Depends on mssd_pkg.
`default_nettype none

module mssd_in_reg (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_ready,
    input  wire mssd_pkg::t_item i_item,
    output logic                o_valid,
    output mssd_pkg::t_item     o_item,
    input  wire logic           i_take
);
    import mssd_pkg::*;

    logic  r_valid, n_valid;
    t_item r_item;

    // Room for a new beat when empty or when the held one leaves now.
    assign o_ready = !r_valid || i_take;
    assign n_valid = (i_valid && o_ready) || (r_valid && !i_take);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

`default_nettype wire

>>> rtl/mssd_engine.sv
// Display state and per-beat frame logic: load handling with blank frames,
// digit extraction by reciprocal multiply, dash and restart. Depends on mssd_pkg.
`default_nettype none

module mssd_engine #(
    parameter int NUM_DIGITS = mssd_pkg::NUM_DIGITS_DEF
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    input  wire mssd_pkg::t_item i_item,
    output logic                 o_take,
    input  wire logic            i_out_room,
    output logic                 o_emit,
    output mssd_pkg::t_result    o_result
);
    import mssd_pkg::*;

    localparam int BLANK_COUNT = (NUM_DIGITS > MAX_BLANKS) ? MAX_BLANKS :
                                 ((NUM_DIGITS < 1) ? 1 : NUM_DIGITS);
    localparam int BLANK_W     = (BLANK_COUNT > 1) ? $clog2(BLANK_COUNT) : 1;
    localparam logic [BLANK_W-1:0] BLANK_LAST = BLANK_W'(BLANK_COUNT - 1);

    logic [POS_W-1:0]   r_digit_pos, n_digit_pos;
    logic [MAG_W-1:0]   r_rem_mag, n_rem_mag;
    logic [MAG_W-1:0]   r_stored_mag, n_stored_mag;
    logic               r_negative, n_negative;
    logic [BLANK_W-1:0] r_blank_idx, n_blank_idx;

    logic                      w_is_load;
    logic                      w_in_range;
    logic signed [VALUE_W-1:0] w_value;
    logic [VALUE_W-1:0]        w_abs;
    logic [DIV_PROD_W-1:0]     w_prod;
    logic [MAG_W-1:0]          w_quot;
    logic [MAG_W-1:0]          w_rem_full;
    logic [DIGIT_W-1:0]        w_digit;
    logic                      w_dash;
    logic [MAG_W-1:0]          w_tick_mag;
    logic [POS_W-1:0]          w_tick_pos;
    logic                      w_blank_last;

    assign w_is_load = (i_item.action == ACT_LOAD);
    assign o_emit    = i_valid && i_out_room;
    assign w_blank_last = (r_blank_idx == BLANK_LAST);
    // A load leaves with its last blank frame; a tick leaves at once.
    assign o_take    = o_emit && (!w_is_load || w_blank_last);

    // Load: zero values outside the displayable range and split into sign and magnitude.
    assign w_value    = i_item.value;
    assign w_in_range = (w_value >= MIN_NEGATIVE) && (w_value <= MAX_POSITIVE);
    assign w_abs      = w_value[VALUE_W-1] ? VALUE_W'(-w_value) : VALUE_W'(w_value);

    // Tick: next digit of the remaining magnitude, least significant first.
    assign w_prod     = DIV_PROD_W'(r_rem_mag) * DIV_PROD_W'(DIV10_RECIP);
    assign w_quot     = MAG_W'(w_prod[DIV_PROD_W-1:DIV10_SHIFT]);
    assign w_rem_full = r_rem_mag - MAG_W'(w_quot * TEN);
    assign w_digit    = w_rem_full[DIGIT_W-1:0];
    assign w_dash     = r_negative && (r_rem_mag == '0);
    assign w_tick_mag = w_dash ? r_rem_mag : w_quot;
    assign w_tick_pos = w_dash ? r_digit_pos : POS_W'(r_digit_pos + 1'b1);

    // Result of the current beat.
    always_comb begin
        if (w_is_load) begin
            o_result.shift_frame  = FRAME_BLANK;
            o_result.digit_enable = f_enable(POS_W'(r_blank_idx));
            o_result.last_of_run  = w_blank_last;
        end else begin
            o_result.shift_frame  = f_frame(w_dash ? SEG_DASH : f_segments(w_digit));
            o_result.digit_enable = f_enable(r_digit_pos);
            o_result.last_of_run  = 1'b1;
        end
    end

    // Next state.
    always_comb begin
        n_digit_pos  = r_digit_pos;
        n_rem_mag    = r_rem_mag;
        n_stored_mag = r_stored_mag;
        n_negative   = r_negative;
        n_blank_idx  = r_blank_idx;
        if (o_emit && w_is_load) begin
            if (w_blank_last) begin
                n_blank_idx  = '0;
                n_digit_pos  = '0;
                n_negative   = w_in_range && w_value[VALUE_W-1];
                n_stored_mag = w_in_range ? w_abs[MAG_W-1:0] : '0;
                n_rem_mag    = w_in_range ? w_abs[MAG_W-1:0] : '0;
            end else begin
                n_blank_idx = r_blank_idx + BLANK_W'(1);
            end
        end else if (o_emit) begin
            // Value fully shown: restart from the stored magnitude.
            if ((w_tick_mag == '0) && (!r_negative || w_dash)) begin
                n_digit_pos = '0;
                n_rem_mag   = r_stored_mag;
            end else begin
                n_digit_pos = w_tick_pos;
                n_rem_mag   = w_tick_mag;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_digit_pos  <= '0;
            r_rem_mag    <= '0;
            r_stored_mag <= '0;
            r_negative   <= 1'b0;
            r_blank_idx  <= '0;
        end else begin
            r_digit_pos  <= n_digit_pos;
            r_rem_mag    <= n_rem_mag;
            r_stored_mag <= n_stored_mag;
            r_negative   <= n_negative;
            r_blank_idx  <= n_blank_idx;
        end
    end

endmodule

`default_nettype wire

>>> rtl/mssd_out_reg.sv
// Output register of the display driver: holds one result beat until the
// consumer takes it. Depends on mssd_pkg.
`default_nettype none

module mssd_out_reg (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_load,
    input  wire mssd_pkg::t_result i_result,
    output logic                   o_room,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output mssd_pkg::t_result      o_result
);
    import mssd_pkg::*;

    logic    r_valid, n_valid;
    t_result r_result;

    // A new beat may enter when empty or when the held beat leaves now.
    assign o_room  = !r_valid || i_ready;
    assign n_valid = i_load || (r_valid && !i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

`default_nettype wire

>>> rtl/multiplexed_seven_segment_driver_core.sv
// Top level of the multiplexed seven-segment display driver core.
// Depends on mssd_pkg, mssd_in_reg, mssd_engine and mssd_out_reg.
`default_nettype none

// Drives a multiplexed display one digit per refresh tick. A load beat
// (action = 1) stores the sign and magnitude of a signed value, shown as 0
// when below -999 or above 9999, and answers with min(NUM_DIGITS, 4) blank
// frames walking the digit enables, the last one flagged by o_last_of_run.
// Each tick beat (action = 0) yields one frame: the next decimal digit, least
// significant first without leading zeros, then a dash for negative values,
// after which the display restarts from the stored magnitude. A tick yields
// one frame and a load min(NUM_DIGITS, 4); the single result register takes
// one frame per cycle while it has room. A beat reaches the output through
// the input register, the engine logic and the result register. The input
// register takes one further beat while a result waits to be taken.
module multiplexed_seven_segment_driver_core #(
    parameter int NUM_DIGITS = mssd_pkg::NUM_DIGITS_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_ready,
    input  wire logic                                i_action,
    input  wire logic signed [mssd_pkg::VALUE_W-1:0] i_value,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_ready,
    output logic [mssd_pkg::FRAME_W-1:0]             o_shift_frame,
    output logic [mssd_pkg::ENABLE_W-1:0]            o_digit_enable,
    output logic                                     o_last_of_run
);
    import mssd_pkg::*;

    t_item   w_in_item;
    t_item   w_held_item;
    logic    w_held_valid;
    logic    w_take;
    logic    w_room;
    logic    w_emit;
    t_result w_result;
    t_result w_out_result;

    assign w_in_item.action = i_action;
    assign w_in_item.value  = i_value;

    // Input register.
    mssd_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_item  (w_in_item),
        .o_valid (w_held_valid),
        .o_item  (w_held_item),
        .i_take  (w_take)
    );

    // Display state and frame generation.
    mssd_engine #(
        .NUM_DIGITS (NUM_DIGITS)
    ) u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_held_valid),
        .i_item     (w_held_item),
        .o_take     (w_take),
        .i_out_room (w_room),
        .o_emit     (w_emit),
        .o_result   (w_result)
    );

    // Result register.
    mssd_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_emit),
        .i_result (w_result),
        .o_room   (w_room),
        .o_valid  (o_out_valid),
        .i_ready  (i_out_ready),
        .o_result (w_out_result)
    );

    assign o_shift_frame  = w_out_result.shift_frame;
    assign o_digit_enable = w_out_result.digit_enable;
    assign o_last_of_run  = w_out_result.last_of_run;

endmodule

`default_nettype wire
